// ===== src/amc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, operation codes and CORDIC constants for the 2D affine composer.
package amc_pkg;

  localparam int WORD_W     = 48;
  localparam int OP_W       = 3;
  localparam int MUL_W      = 64;
  localparam int ANGLE_FRAC = 40;
  localparam int ATAN_N     = 32;
  localparam int ATAN_IDX_W = 5;
  localparam int ATAN_SH    = 62 - ANGLE_FRAC;
  localparam int CORD_XW    = 44;
  localparam int CORD_ZW    = 45;

  localparam logic [OP_W-1:0] OP_IDENTITY  = 3'd0;
  localparam logic [OP_W-1:0] OP_ROTATE    = 3'd1;
  localparam logic [OP_W-1:0] OP_TRANSLATE = 3'd2;
  localparam logic [OP_W-1:0] OP_SCALE     = 3'd3;
  localparam logic [OP_W-1:0] OP_SHEAR     = 3'd4;
  localparam logic [OP_W-1:0] OP_MIRROR    = 3'd5;

  localparam logic [CORD_XW-1:0] CORDIC_GAIN = 44'd667681663047;

  typedef logic [ATAN_N-1:0][ANGLE_FRAC-1:0] atan_tab_t;

  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic signed [WORD_W-1:0] operand_a;
    logic signed [WORD_W-1:0] operand_b;
  } cmd_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] m00;
    logic signed [WORD_W-1:0] m01;
    logic signed [WORD_W-1:0] m02;
    logic signed [WORD_W-1:0] m10;
    logic signed [WORD_W-1:0] m11;
    logic signed [WORD_W-1:0] m12;
    logic signed [WORD_W-1:0] m20;
    logic signed [WORD_W-1:0] m21;
    logic signed [WORD_W-1:0] m22;
  } mat_t;

  // unsigned 64-bit quotient by restoring long division (elaboration only)
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rmd;
    logic [63:0] quo;
    rmd = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rmd = {rmd[63:0], num[i]};
      if (rmd >= {1'b0, den}) begin
        rmd    = rmd - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // atan(1/n) with 62 fraction bits, alternating series (elaboration only)
  function automatic logic [63:0] atan_inv(input logic [63:0] n);
    logic [63:0] p;
    logic [63:0] n2;
    logic [63:0] sum;
    logic [63:0] t;
    p   = udiv64(64'd1 << 62, n);
    n2  = n * n;
    sum = 64'd0;
    for (int k = 0; k < 64; k++) begin
      if (p != 64'd0) begin
        t = udiv64(p, 64'(2 * k + 1));
        if ((k & 1) == 1) sum = sum - t;
        else sum = sum + t;
        p = udiv64(p, n2);
      end
    end
    return sum;
  endfunction

  localparam logic [63:0] QUARTER_Q62 = 64'd4 * atan_inv(64'd5) - atan_inv(64'd239);
  localparam logic [63:0] DEG_RAD_Q62 = QUARTER_Q62 / 64'd45;

  function automatic atan_tab_t build_atan();
    atan_tab_t   tab;
    logic [63:0] v;
    for (int i = 0; i < ATAN_N; i++) begin
      if (i == 0) v = QUARTER_Q62;
      else v = atan_inv(64'd1 << i);
      tab[i] = ANGLE_FRAC'((v + (64'd1 << (ATAN_SH - 1))) >> ATAN_SH);
    end
    return tab;
  endfunction

  localparam atan_tab_t ATAN_TAB = build_atan();

endpackage

// ===== src/affine_matrix_composer_2d.sv =====
`timescale 1ns / 1ps
// Top level: 2D homogeneous affine matrix composer with shared multiplier.
//
// Holds a 3x3 transform matrix (48-bit signed words, FRAC_BITS fraction
// bits, identity after reset) and post-multiplies it by one elementary
// matrix per command: identity reload, rotate (degrees), translate, scale,
// shear or mirror about the x axis. Every command, including the unused
// codes 6 and 7, returns all nine updated elements in one output transfer.
// One command is in flight at a time; in_stall is high from acceptance until
// the result is moved to the output register, which then waits on out_stall
// while the next command may already be taken. Identity and unused codes go
// straight to the done state and release in_stall once the output register
// is loaded. The other operations run the 27 products of the matrix multiply
// through one 64x64 multiplier built from a 32x32 array, one
// multiply-accumulate after another, element by element. Rotate first runs
// the modulo-360 reduction by one reciprocal product, the fold, one
// radian-conversion product and the CORDIC rotation. A result held in the
// output register under out_stall keeps the next command's result waiting
// in the done state, with in_stall high, for as long as the stall lasts.
// Products round to nearest (ties away from zero); each element's sum of
// three products saturates to the word range.
module affine_matrix_composer_2d #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 18
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  amc_pkg::cmd_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output amc_pkg::mat_t  out_data
);
  import amc_pkg::*;

  localparam int W        = WORD_W;
  localparam int RW       = FRAC_BITS + 10;
  localparam int SUMW     = (2*W - FRAC_BITS + 2 > W + 2) ? 2*W - FRAC_BITS + 2 : W + 2;
  localparam int SH_T     = FRAC_BITS;
  localparam int SH_A     = FRAC_BITS + 62 - ANGLE_FRAC;
  localparam int FRAC_SH  = ANGLE_FRAC - FRAC_BITS;
  localparam int PW       = 2 * MUL_W;

  localparam logic [RW-1:0] FULL_ANG  = RW'(360) << FRAC_BITS;
  localparam logic [RW-1:0] HALF_ANG  = RW'(180) << FRAC_BITS;
  localparam logic [RW-1:0] QUART_ANG = RW'(90) << FRAC_BITS;
  localparam logic [PW-1:0] HALF_T    = PW'(1) << (SH_T - 1);
  localparam logic [PW-1:0] HALF_A    = PW'(1) << (SH_A - 1);
  localparam logic [W-1:0]  ONE_W     = W'(1) << FRAC_BITS;
  localparam logic [W-1:0]  NEG_ONE_W = W'(0) - ONE_W;
  // ceil(2^64 / 45): quotient by 45 is the upper half of the product
  localparam logic [MUL_W-1:0] RECIP45 = 64'hFFFF_FFFF_FFFF_FFFF / 64'd45 + 64'd1;

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MOD   = 4'd1;
  localparam logic [3:0] S_FOLD  = 4'd2;
  localparam logic [3:0] S_RMUL  = 4'd3;
  localparam logic [3:0] S_RWAIT = 4'd4;
  localparam logic [3:0] S_CORD  = 4'd5;
  localparam logic [3:0] S_CWAIT = 4'd6;
  localparam logic [3:0] S_MUL   = 4'd7;
  localparam logic [3:0] S_MWAIT = 4'd8;
  localparam logic [3:0] S_ACC   = 4'd9;
  localparam logic [3:0] S_WR    = 4'd10;
  localparam logic [3:0] S_COPY  = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;
  localparam logic [3:0] S_MODW  = 4'd13;

  // saturate a 64-bit signed value to the word range
  function automatic logic [W-1:0] sat64(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = $signed({{(65-W){1'b0}}, {(W-1){1'b1}}});
    lo = ~hi;
    if (v > hi) return hi[W-1:0];
    else if (v < lo) return lo[W-1:0];
    else return v[W-1:0];
  endfunction

  // saturate an element sum to the word range
  function automatic logic [W-1:0] satsum(input logic signed [SUMW-1:0] v);
    logic signed [SUMW-1:0] hi;
    logic signed [SUMW-1:0] lo;
    hi = $signed({{(SUMW-W+1){1'b0}}, {(W-1){1'b1}}});
    lo = ~hi;
    if (v > hi) return hi[W-1:0];
    else if (v < lo) return lo[W-1:0];
    else return v[W-1:0];
  endfunction

  logic [3:0]              state_r, state_nxt;
  logic [W-1:0]            m_r  [9];
  logic [W-1:0]            e_r  [9];
  logic [W-1:0]            nm_r [9];
  logic [W-1:0]            e_cmd [9];
  logic [W-1:0]            e_rot [9];
  logic [W-1:0]            mag_r;
  logic [RW-1:0]           rem_r, rem_calc;
  logic [MUL_W-1:0]        xdiv, quo, quo45, r45;
  logic                    neg_r, ng_r, flip_r;
  logic [RW-1:0]           r1, m1, m2;
  logic                    ng1, ng2, fl2;
  logic [RW-1:0]           m_ang_r;
  logic signed [CORD_ZW-1:0] z_r, z_nxt;
  logic [CORD_ZW-1:0]      rad_z;
  logic [1:0]              row_r, col_r, k_r;
  logic [3:0]              mi, ei, wi;
  logic [W-1:0]            mval, eval, mmag, emag;
  logic signed [SUMW-1:0]  sum_r;
  logic [SUMW-1:0]         rnd_r;
  logic                    pneg_r;
  logic [PW-1:0]           rnd_t, rnd_a;
  logic                    mul_start, mul_done;
  logic [MUL_W-1:0]        mul_a, mul_b;
  logic [PW-1:0]           mul_prod;
  logic                    cord_start, cord_done;
  logic signed [CORD_XW-1:0] cord_x, cord_y;
  logic signed [63:0]      cx64, cy64, cs64, sn64;
  logic                    in_acc, load_out;
  logic                    out_valid_r;
  mat_t                    out_data_r;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign load_out = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  // operand selection for the shared multiplier
  assign mi   = 4'(row_r) * 4'd3 + 4'(k_r);
  assign ei   = 4'(k_r) * 4'd3 + 4'(col_r);
  assign wi   = 4'(row_r) * 4'd3 + 4'(col_r);
  assign mval = m_r[mi];
  assign eval = e_r[ei];
  assign mmag = mval[W-1] ? (~mval + W'(1)) : mval;
  assign emag = eval[W-1] ? (~eval + W'(1)) : eval;

  assign mul_start = (state_r == S_MOD) || (state_r == S_RMUL) || (state_r == S_MUL);
  assign mul_a     = (state_r == S_MOD)  ? xdiv :
                     (state_r == S_RMUL) ? MUL_W'(m_ang_r) : MUL_W'(mmag);
  assign mul_b     = (state_r == S_MOD)  ? RECIP45 :
                     (state_r == S_RMUL) ? DEG_RAD_Q62 : MUL_W'(emag);
  assign cord_start = (state_r == S_CORD);

  amc_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a_in  (mul_a),
    .b_in  (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  amc_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cord_start),
    .z_in  (z_r),
    .done  (cord_done),
    .x_out (cord_x),
    .y_out (cord_y)
  );

  // rounded magnitudes: matrix product and degree-to-radian conversion
  assign rnd_t = (mul_prod + HALF_T) >> SH_T;
  assign rnd_a = (mul_prod + HALF_A) >> SH_A;
  assign rad_z = rnd_a[CORD_ZW-1:0];
  assign z_nxt = ng_r ? $signed(CORD_ZW'(0) - rad_z) : $signed(rad_z);

  // modulo 360 degrees: 360 = 45 * 8, so reduce the integer degrees
  // above the low three bits by 45 with a reciprocal product
  assign xdiv     = MUL_W'(mag_r >> (FRAC_BITS + 3));
  assign quo      = mul_prod[PW-1:MUL_W];
  assign quo45    = (quo << 5) + (quo << 3) + (quo << 2) + quo;
  assign r45      = xdiv - quo45;
  assign rem_calc = {1'b0, r45[5:0], mag_r[FRAC_BITS+2:0]};

  // fold the reduced angle into [-90, 90]
  always_comb begin
    r1  = (neg_r && rem_r != '0) ? FULL_ANG - rem_r : rem_r;
    ng1 = 1'b0;
    m1  = r1;
    if (r1 > HALF_ANG) begin
      m1  = FULL_ANG - r1;
      ng1 = 1'b1;
    end
    m2  = m1;
    ng2 = ng1;
    fl2 = 1'b0;
    if (m1 > QUART_ANG) begin
      m2  = HALF_ANG - m1;
      ng2 = !ng1;
      fl2 = 1'b1;
    end
  end

  // CORDIC result to FRAC_BITS, round half up, undo the 180 degree fold
  assign cx64 = (64'(cord_x) + (64'sd1 <<< (FRAC_SH - 1))) >>> FRAC_SH;
  assign cy64 = (64'(cord_y) + (64'sd1 <<< (FRAC_SH - 1))) >>> FRAC_SH;
  assign cs64 = flip_r ? -cx64 : cx64;
  assign sn64 = flip_r ? -cy64 : cy64;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      e_rot[i] = (i == 0 || i == 4 || i == 8) ? ONE_W : '0;
      e_cmd[i] = (i == 0 || i == 4 || i == 8) ? ONE_W : '0;
    end
    e_rot[0] = sat64(cs64);
    e_rot[1] = sat64(sn64);
    e_rot[3] = sat64(-sn64);
    e_rot[4] = sat64(cs64);
    case (in_data.operation)
      OP_TRANSLATE: begin
        e_cmd[2] = in_data.operand_a;
        e_cmd[5] = in_data.operand_b;
      end
      OP_SCALE: begin
        e_cmd[0] = in_data.operand_a;
        e_cmd[4] = in_data.operand_b;
      end
      OP_SHEAR: begin
        e_cmd[1] = in_data.operand_a;
        e_cmd[3] = in_data.operand_b;
      end
      OP_MIRROR: e_cmd[4] = NEG_ONE_W;
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_data.operation) inside
            OP_ROTATE: state_nxt = S_MOD;
            OP_TRANSLATE, OP_SCALE, OP_SHEAR, OP_MIRROR: state_nxt = S_MUL;
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_MOD:   state_nxt = S_MODW;
      S_MODW:  if (mul_done) state_nxt = S_FOLD;
      S_FOLD:  state_nxt = S_RMUL;
      S_RMUL:  state_nxt = S_RWAIT;
      S_RWAIT: if (mul_done) state_nxt = S_CORD;
      S_CORD:  state_nxt = S_CWAIT;
      S_CWAIT: if (cord_done) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_MWAIT;
      S_MWAIT: if (mul_done) state_nxt = S_ACC;
      S_ACC:   state_nxt = (k_r == 2'd2) ? S_WR : S_MUL;
      S_WR:    state_nxt = (row_r == 2'd2 && col_r == 2'd2) ? S_COPY : S_MUL;
      S_COPY:  state_nxt = S_DONE;
      S_DONE:  if (load_out) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state and the stored matrix
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 9; i++) m_r[i] <= (i == 0 || i == 4 || i == 8) ? ONE_W : '0;
    end else begin
      state_r <= state_nxt;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (in_acc && in_data.operation == OP_IDENTITY) begin
        for (int i = 0; i < 9; i++) m_r[i] <= (i == 0 || i == 4 || i == 8) ? ONE_W : '0;
      end else if (state_r == S_COPY) begin
        for (int i = 0; i < 9; i++) m_r[i] <= nm_r[i];
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        neg_r     <= in_data.operand_a[W-1];
        mag_r     <= in_data.operand_a[W-1] ? (~in_data.operand_a + W'(1))
                                            : in_data.operand_a;
        rem_r     <= '0;
        row_r     <= 2'd0;
        col_r     <= 2'd0;
        k_r       <= 2'd0;
        sum_r     <= '0;
        for (int i = 0; i < 9; i++) e_r[i] <= e_cmd[i];
      end
      S_MODW: if (mul_done) rem_r <= rem_calc;
      S_FOLD: begin
        m_ang_r <= m2;
        ng_r    <= ng2;
        flip_r  <= fl2;
      end
      S_RWAIT: if (mul_done) z_r <= z_nxt;
      S_CWAIT: begin
        if (cord_done) begin
          for (int i = 0; i < 9; i++) e_r[i] <= e_rot[i];
        end
      end
      S_MUL:   pneg_r <= mval[W-1] ^ eval[W-1];
      S_MWAIT: if (mul_done) rnd_r <= rnd_t[SUMW-1:0];
      S_ACC: begin
        sum_r <= pneg_r ? sum_r - $signed(rnd_r) : sum_r + $signed(rnd_r);
        if (k_r != 2'd2) k_r <= k_r + 2'd1;
      end
      S_WR: begin
        nm_r[wi] <= satsum(sum_r);
        sum_r    <= '0;
        k_r      <= 2'd0;
        if (col_r == 2'd2) begin
          col_r <= 2'd0;
          row_r <= row_r + 2'd1;
        end else begin
          col_r <= col_r + 2'd1;
        end
      end
      default: ;
    endcase
    if (load_out) begin
      out_data_r.m00 <= m_r[0];
      out_data_r.m01 <= m_r[1];
      out_data_r.m02 <= m_r[2];
      out_data_r.m10 <= m_r[3];
      out_data_r.m11 <= m_r[4];
      out_data_r.m12 <= m_r[5];
      out_data_r.m20 <= m_r[6];
      out_data_r.m21 <= m_r[7];
      out_data_r.m22 <= m_r[8];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== src/amc_mul.sv =====
`timescale 1ns / 1ps
// Shared unsigned 64x64 multiplier, one 32x32 partial product per cycle.
module amc_mul (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [amc_pkg::MUL_W-1:0]      a_in,
  input  logic [amc_pkg::MUL_W-1:0]      b_in,
  output logic                           done,
  output logic [2*amc_pkg::MUL_W-1:0]    prod
);
  import amc_pkg::*;

  localparam int HW = MUL_W / 2;

  logic [MUL_W-1:0]   a_r, b_r;
  logic [2*MUL_W-1:0] acc_r, pp_ext, part;
  logic [HW-1:0]      a_h, b_h;
  logic [MUL_W-1:0]   pp;
  logic [1:0]         cnt_r;
  logic               busy_r, done_r;

  assign a_h    = cnt_r[1] ? a_r[MUL_W-1:HW] : a_r[HW-1:0];
  assign b_h    = cnt_r[0] ? b_r[MUL_W-1:HW] : b_r[HW-1:0];
  assign pp     = MUL_W'(a_h) * MUL_W'(b_h);
  assign pp_ext = (2*MUL_W)'(pp);

  always_comb begin
    case (cnt_r)
      2'b00:   part = pp_ext;
      2'b01:   part = pp_ext << HW;
      2'b10:   part = pp_ext << HW;
      default: part = pp_ext << MUL_W;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 2'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a_in;
      b_r   <= b_in;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_r + part;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// ===== src/amc_cordic.sv =====
`timescale 1ns / 1ps
// Rotation-mode CORDIC, one micro-rotation per cycle.
module amc_cordic #(
  parameter int STEPS = 18
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [amc_pkg::CORD_ZW-1:0]   z_in,
  output logic                                 done,
  output logic signed [amc_pkg::CORD_XW-1:0]   x_out,
  output logic signed [amc_pkg::CORD_XW-1:0]   y_out
);
  import amc_pkg::*;

  localparam int NST = (STEPS < ATAN_N) ? STEPS : ATAN_N;
  localparam int CW  = $clog2(NST + 1);

  logic signed [CORD_XW-1:0] x_r, y_r, x_nxt, y_nxt, dx, dy;
  logic signed [CORD_ZW-1:0] z_r, z_nxt, at;
  logic [CW-1:0]             cnt_r;
  logic                      busy_r, done_r;

  assign dx = y_r >>> cnt_r;
  assign dy = x_r >>> cnt_r;
  assign at = $signed(CORD_ZW'(ATAN_TAB[ATAN_IDX_W'(cnt_r)]));

  always_comb begin
    if (!z_r[CORD_ZW-1]) begin
      x_nxt = x_r - dx;
      y_nxt = y_r + dy;
      z_nxt = z_r - at;
    end else begin
      x_nxt = x_r + dx;
      y_nxt = y_r - dy;
      z_nxt = z_r + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(NST - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= $signed(CORDIC_GAIN);
      y_r <= '0;
      z_r <= z_in;
    end else if (busy_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign done  = done_r;
  assign x_out = x_r;
  assign y_out = y_r;

endmodule

// ===== test/affine_matrix_composer_2d_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the 2D affine matrix composer.
module affine_matrix_composer_2d_test;
  import amc_pkg::*;

  localparam int  ONE_Q     = 1 << 16;
  localparam int  FRAC      = 16;
  localparam int  STEPS     = 18;
  localparam int  N_RANDOM  = 1730;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam int  DRAIN_CYCLES = 400;

  // operation codes with no defined transform
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

  typedef struct {
    cmd_t cmd;
    bit   hold;   // wait for all results to come back before driving this one
  } pending_cmd_t;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  cmd_t  in_data = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  mat_t  out_data;

  pending_cmd_t cmd_queue[$];
  mat_t         expected_mats[$];
  logic [63:0]  matrix_state[9];
  int           error_count = 0;
  longint       cycle_count = 0;
  int           send_gap = 0;
  int           recv_stall = 0;
  bit           burst_mode = 1'b0;
  bit           stim_done = 1'b0;

  affine_matrix_composer_2d dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Fixed-point predictor
  // ---------------------------------------------------------------------

  // signed a*b >> s, round to nearest, ties away from zero
  function automatic logic [127:0] round_product(logic [63:0] a, logic [63:0] b, int s);
    logic [127:0] p;
    logic [63:0]  ma;
    logic [63:0]  mb;
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    p  = {64'd0, ma} * {64'd0, mb};
    p  = (p + (128'd1 << (s - 1))) >> s;
    return (a[63] ^ b[63]) ? -p : p;
  endfunction

  // saturate a wide signed value to the 48-bit word, sign-extended to 64
  function automatic logic [63:0] sat_word(logic [127:0] v);
    logic signed [127:0] sv;
    sv = $signed(v);
    if (sv > $signed(128'h7FFF_FFFF_FFFF)) return 64'h0000_7FFF_FFFF_FFFF;
    if (sv < -$signed(128'h8000_0000_0000)) return 64'hFFFF_8000_0000_0000;
    return v[63:0];
  endfunction

  function automatic logic [63:0] shift_arith(logic [63:0] v, int s);
    return $unsigned($signed(v) >>> s);
  endfunction

  // CORDIC sine/cosine of an angle in degrees (Q.16), with quadrant folding
  task automatic rotation_terms(input logic [63:0] angle, output logic [63:0] cs,
                                output logic [63:0] sn);
    logic [63:0] full;
    logic [63:0] half;
    logic [63:0] quart;
    logic [63:0] mag;
    logic [63:0] r;
    logic [63:0] m;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] z;
    logic [63:0] dx;
    logic [63:0] dy;
    logic [63:0] at;
    bit          ng;
    bit          flip;
    full  = 64'd360 << FRAC;
    half  = 64'd180 << FRAC;
    quart = 64'd90 << FRAC;
    ng    = 1'b0;
    flip  = 1'b0;
    mag   = angle[63] ? -angle : angle;
    r     = mag % full;
    if (angle[63] && r != 0) r = full - r;
    if (r > half) begin
      m  = full - r;
      ng = 1'b1;
    end else begin
      m = r;
    end
    if (m > quart) begin
      m    = half - m;
      ng   = !ng;
      flip = 1'b1;
    end
    z = 64'(round_product(m, DEG_RAD_Q62, FRAC + 62 - ANGLE_FRAC));
    if (ng) z = -z;
    x = 64'(CORDIC_GAIN);
    y = 64'd0;
    for (int i = 0; i < STEPS; i++) begin
      dx = shift_arith(y, i);
      dy = shift_arith(x, i);
      at = 64'(ATAN_TAB[i]);
      if (!z[63]) begin
        x = x - dx; y = y + dy; z = z - at;
      end else begin
        x = x + dx; y = y - dy; z = z + at;
      end
    end
    // back to FRAC_BITS, round half up
    x = shift_arith(x + (64'd1 << (ANGLE_FRAC - FRAC - 1)), ANGLE_FRAC - FRAC);
    y = shift_arith(y + (64'd1 << (ANGLE_FRAC - FRAC - 1)), ANGLE_FRAC - FRAC);
    cs = flip ? -x : x;
    sn = flip ? -y : y;
  endtask

  task automatic load_identity();
    for (int k = 0; k < 9; k++) matrix_state[k] = (k % 4 == 0) ? 64'(ONE_Q) : 64'd0;
  endtask

  // apply one command to the predicted matrix and return the emitted result
  task automatic compose_matrix(input cmd_t cmd, output mat_t result);
    logic [63:0]  elem[9];
    logic [63:0]  nm[9];
    logic [63:0]  a;
    logic [63:0]  b;
    logic [63:0]  cs;
    logic [63:0]  sn;
    logic [127:0] acc;
    a = 64'(cmd.operand_a);
    b = 64'(cmd.operand_b);
    for (int k = 0; k < 9; k++) elem[k] = (k % 4 == 0) ? 64'(ONE_Q) : 64'd0;
    if (cmd.operation == OP_IDENTITY) begin
      load_identity();
    end else if (cmd.operation <= OP_MIRROR) begin
      case (cmd.operation)
        OP_ROTATE: begin
          rotation_terms(a, cs, sn);
          elem[0] = cs; elem[1] = sn; elem[3] = -sn; elem[4] = cs;
        end
        OP_TRANSLATE: begin
          elem[2] = a; elem[5] = b;
        end
        OP_SCALE: begin
          elem[0] = a; elem[4] = b;
        end
        OP_SHEAR: begin
          elem[1] = a; elem[3] = b;
        end
        default: begin
          elem[4] = -64'(ONE_Q);
        end
      endcase
      for (int k = 0; k < 9; k++) elem[k] = sat_word({{64{elem[k][63]}}, elem[k]});
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          acc = '0;
          for (int k = 0; k < 3; k++)
            acc = acc + round_product(matrix_state[r*3+k], elem[k*3+c], FRAC);
          nm[r*3+c] = sat_word(acc);
        end
      end
      for (int k = 0; k < 9; k++) matrix_state[k] = nm[k];
    end
    // unused codes fall through with the matrix untouched
    for (int k = 0; k < 9; k++) result[(8-k)*WORD_W +: WORD_W] = matrix_state[k][WORD_W-1:0];
  endtask

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  function automatic logic [WORD_W-1:0] any_word();
    return WORD_W'({$urandom, $urandom});
  endfunction

  // small value within +-range_int in Q.16
  function automatic logic [WORD_W-1:0] near_word(int range_int);
    longint v;
    v = longint'($urandom_range(0, 2 * range_int * ONE_Q)) - longint'(range_int) * ONE_Q;
    return v[WORD_W-1:0];
  endfunction

  task automatic push_cmd(logic [OP_W-1:0] op, logic [WORD_W-1:0] a,
                          logic [WORD_W-1:0] b, bit hold = 1'b0);
    pending_cmd_t p;
    p.cmd.operation = op;
    p.cmd.operand_a = a;
    p.cmd.operand_b = b;
    p.hold = hold;
    cmd_queue.push_back(p);
  endtask

  function automatic logic [WORD_W-1:0] deg(int d);
    return WORD_W'(longint'(d) * ONE_Q);
  endfunction

  function automatic logic [OP_W-1:0] OP_OW_CODE(int pick);
    return (pick[0]) ? OP_UNUSED_HI : OP_UNUSED_LO;
  endfunction

  initial begin
    logic [OP_W-1:0]   op;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    int                pick;
    load_identity();

    // directed: extremes, every operation, the quadrant folds and unused codes
    push_cmd(OP_ROTATE, deg(0), any_word());
    push_cmd(OP_ROTATE, deg(90), '1);
    push_cmd(OP_ROTATE, deg(-90), '0);
    push_cmd(OP_ROTATE, deg(180), any_word());
    push_cmd(OP_ROTATE, deg(270), any_word());
    push_cmd(OP_ROTATE, deg(360), any_word());
    push_cmd(OP_ROTATE, deg(-360), any_word());
    push_cmd(OP_ROTATE, deg(45) + 1, any_word());
    push_cmd(OP_ROTATE, {1'b0, {(WORD_W-1){1'b1}}}, any_word());
    push_cmd(OP_ROTATE, {1'b1, {(WORD_W-1){1'b0}}}, any_word());
    push_cmd(OP_IDENTITY, '1, '1);
    push_cmd(OP_TRANSLATE, {1'b0, {(WORD_W-1){1'b1}}}, {1'b1, {(WORD_W-1){1'b0}}});
    push_cmd(OP_TRANSLATE, {1'b0, {(WORD_W-1){1'b1}}}, {1'b1, {(WORD_W-1){1'b0}}});
    push_cmd(OP_MIRROR, any_word(), any_word());
    push_cmd(OP_SCALE, {1'b0, {(WORD_W-1){1'b1}}}, {1'b1, {(WORD_W-1){1'b0}}});
    push_cmd(OP_UNUSED_LO, any_word(), any_word());
    push_cmd(OP_UNUSED_HI, any_word(), any_word(), 1'b1);
    push_cmd(OP_IDENTITY, '0, '0);
    push_cmd(OP_SHEAR, deg(2), deg(-3));
    push_cmd(OP_SCALE, '0, '0);
    push_cmd(OP_SHEAR, '1, '1);
    push_cmd(OP_IDENTITY, any_word(), any_word());

    // random: mostly sane transform chains, some full-range noise
    for (int n = 0; n < N_RANDOM; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) op = OP_IDENTITY;
      else if (pick < 10) op = OP_OW_CODE(pick);
      else op = OP_W'($urandom_range(1, 5));
      if ($urandom_range(0, 9) == 0) begin
        a = any_word();
        b = any_word();
      end else begin
        case (op)
          OP_ROTATE:    a = ($urandom_range(0, 1) != 0) ? deg($urandom_range(0, 1440) - 720)
                                                        : near_word(4000);
          OP_TRANSLATE: a = near_word(500);
          default:      a = near_word(2);
        endcase
        b = (op == OP_TRANSLATE) ? near_word(500) : near_word(2);
      end
      push_cmd(op, a, b, (n % 400) == 399);
    end
  end

  // ---------------------------------------------------------------------
  // Reset, driver, monitor
  // ---------------------------------------------------------------------

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  // driver: one transfer per command, random gaps, occasional full drain
  always @(posedge clk) begin
    mat_t next_mat;
    bit   drive;
    if (rst_n) begin
      drive = in_valid;
      if (in_valid && !in_stall) begin
        compose_matrix(in_data, next_mat);
        expected_mats.push_back(next_mat);
        void'(cmd_queue.pop_front());
        drive = 1'b0;
        if ($urandom_range(0, 199) == 0) burst_mode = !burst_mode;
        send_gap = burst_mode ? 0 : $urandom_range(0, 14);
      end
      if (!drive) begin
        if (send_gap > 0) begin
          send_gap = send_gap - 1;
        end else if (cmd_queue.size() != 0) begin
          if (!cmd_queue[0].hold || expected_mats.size() == 0) begin
            in_data <= cmd_queue[0].cmd;
            drive = 1'b1;
          end
        end else begin
          stim_done = 1'b1;
        end
      end
      in_valid <= drive;
    end
  end

  // monitor: field-by-field compare against the oldest expected matrix
  always @(posedge clk) begin
    mat_t  want;
    string names[9];
    names = '{"m00", "m01", "m02", "m10", "m11", "m12", "m20", "m21", "m22"};
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_mats.size() == 0) begin
          $error("result transfer with no expected matrix");
          error_count++;
        end else begin
          want = expected_mats.pop_front();
          for (int k = 0; k < 9; k++) begin
            if (want[(8-k)*WORD_W +: WORD_W] !== out_data[(8-k)*WORD_W +: WORD_W]) begin
              $error("%s expected %h actual %h", names[k],
                     want[(8-k)*WORD_W +: WORD_W], out_data[(8-k)*WORD_W +: WORD_W]);
              error_count++;
            end
          end
        end
        recv_stall = burst_mode ? 0 : $urandom_range(0, 14);
      end else if (recv_stall > 0) begin
        recv_stall = recv_stall - 1;
      end
      out_stall <= (recv_stall != 0);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // end of run: drain, settle, report
  initial begin
    wait (stim_done && !in_valid && expected_mats.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_mats.size() != 0) begin
      $error("%0d expected matrices never arrived", expected_mats.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
